// File: src/f32sc_pkg.sv
// Shared constants and a helper function for the binary32 scale-by-power-of-two unit.
package f32sc_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ShiftW = 10;
  localparam int unsigned ExpW   = 8;
  localparam int unsigned FracW  = 23;
  localparam int unsigned MantW  = FracW + 1;
  localparam int unsigned LzW    = 5;
  // Wide enough for every biased exponent after the shift count is added.
  localparam int unsigned NewExpW = 11;

  localparam logic [WordW-1:0]  EXP_MASK  = 32'h7F80_0000;
  localparam logic [WordW-1:0]  FRAC_MASK = 32'h007F_FFFF;
  localparam logic [WordW-1:0]  SIGN_MASK = 32'h8000_0000;
  localparam logic [ExpW-1:0]   EXP_ALL_ONES = 8'hFF;
  localparam logic signed [NewExpW-1:0] EXP_OVF   = 11'sd255;
  localparam logic signed [NewExpW-1:0] EXP_MIN_N = 11'sd1;

  // Leading-zero count of a 24-bit significand; a nonzero input is assumed.
  function automatic logic [LzW-1:0] lzc24(input logic [MantW-1:0] v);
    logic [LzW-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < MantW; i++) begin
      if (v[i]) begin
        cnt = LzW'(MantW - 1 - i);
      end
    end
    return cnt;
  endfunction

endpackage

// File: src/float32_scale_by_power_of_two_unit.sv
// Top level: binary32 scale by a signed power of two (ldexp), fully pipelined.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------------
//  input   | in_value_bits[31:0], in_shift_amount[9:0] | start & !busy at rising edge
//  result  | out_result_bits[31:0]                   | out_valid, one-cycle strobe
//
// Cycles: one transaction accepted every cycle; the input register takes it on
// acceptance, and the result register, behind the leading-zero count, significand
// shifter and exponent adder, holds the result that out_valid strobes.
// Reset: rst_n synchronous, active low; clears both stage valid flags only.
// Stalls: none. busy stays low and the receiver takes every strobe.
module float32_scale_by_power_of_two_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [f32sc_pkg::WordW-1:0]         in_value_bits,
  input  logic signed [f32sc_pkg::ShiftW-1:0] in_shift_amount,
  output logic                                out_valid,
  output logic [f32sc_pkg::WordW-1:0]         out_result_bits
);
  import f32sc_pkg::*;

  // ---------------- input register ----------------
  logic                     s1_valid_r;
  logic [WordW-1:0]         s1_value_r;
  logic signed [ShiftW-1:0] s1_shift_r;
  logic                     accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value_r <= in_value_bits;
      s1_shift_r <= in_shift_amount;
    end
  end

  // ---------------- scaling logic ----------------
  logic                      sign;
  logic [ExpW-1:0]           efield;
  logic [FracW-1:0]          frac;
  logic                      is_special;
  logic                      is_subn;
  logic [LzW-1:0]            lz;
  logic [MantW-1:0]          mant;
  logic signed [NewExpW-1:0] exp_in;
  logic signed [NewExpW-1:0] new_exp;
  logic signed [NewExpW-1:0] rsh;
  logic [MantW-1:0]          subn_mant;
  logic [WordW-1:0]          result_nxt;

  assign sign   = s1_value_r[WordW-1];
  assign efield = s1_value_r[WordW-2 -: ExpW];
  assign frac   = s1_value_r[FracW-1:0];

  // NaN/infinity, zero of either sign, or a zero shift pass straight through.
  assign is_special = (efield == EXP_ALL_ONES) || (s1_shift_r == '0)
                   || (s1_value_r[WordW-2:0] == '0);
  assign is_subn    = (efield == '0);

  // Subnormals are normalized: leading one moved to bit 23, exponent 1 - lz.
  assign lz = lzc24({1'b0, frac});

  always_comb begin
    if (is_subn) begin
      mant   = {1'b0, frac} << lz;
      exp_in = EXP_MIN_N - $signed({{(NewExpW-LzW){1'b0}}, lz});
    end else begin
      mant   = {1'b1, frac};
      exp_in = $signed({{(NewExpW-ExpW){1'b0}}, efield});
    end
  end

  assign new_exp = exp_in + NewExpW'(s1_shift_r);
  // Right shift needed to land in the subnormal range.
  assign rsh       = EXP_MIN_N - new_exp;
  assign subn_mant = mant >> rsh[LzW-1:0];

  always_comb begin
    if (is_special) begin
      result_nxt = s1_value_r;
    end else if (new_exp >= EXP_OVF) begin
      result_nxt = {sign, EXP_MASK[WordW-2:0]};
    end else if (new_exp >= EXP_MIN_N) begin
      result_nxt = {sign, new_exp[ExpW-1:0], mant[FracW-1:0]};
    end else if (rsh >= NewExpW'(MantW)) begin
      // Shifted fully out: signed zero.
      result_nxt = {sign, {(WordW-1){1'b0}}};
    end else begin
      result_nxt = {sign, {(WordW-1-MantW){1'b0}}, subn_mant};
    end
  end

  // ---------------- result register ----------------
  logic             out_valid_r;
  logic [WordW-1:0] out_result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_result_r <= result_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_bits = out_result_r;

`ifndef ASSERT_OFF
  // A strobe only follows a transaction held in the input register.
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(s1_valid_r))
    else $error("result strobe without a staged transaction");

  // Sign bit is always kept.
  a_sign_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |=> (out_valid && out_result_bits[WordW-1] == $past(s1_value_r[WordW-1])))
    else $error("result sign differs from operand sign");

  // Pass-through cases return the operand bits unchanged.
  a_passthru: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && is_special) |=> (out_result_bits == $past(s1_value_r)))
    else $error("special operand not passed through");

  // Overflow saturates to signed infinity.
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !is_special && new_exp >= EXP_OVF)
      |=> (out_result_bits[WordW-2:0] == EXP_MASK[WordW-2:0]))
    else $error("overflow did not give infinity");
`endif

endmodule
